>>> src/snb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snb_pkg
// shared types and constants of the segment normal and bisector block
// ----------------------------------------------------------------------------
package snb_pkg;

  localparam int UNIT_FRAC_BITS = 14;
  localparam int SQRT_STEPS     = 33;
  localparam int DIV_STEPS      = UNIT_FRAC_BITS + 1;

  localparam logic [1:0] REG_LENGTH_TOL = 2'd0;
  localparam logic [1:0] REG_BISECT_TOL = 2'd1;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

endpackage

>>> src/snb_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snb_iter
// shared bit-serial unit: floor square root or rounded fraction division,
// one compare and subtract per cycle
// ----------------------------------------------------------------------------
module snb_iter import snb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  iter_cmd_t   cmd,
  input  logic [65:0] radicand,
  input  logic [47:0] numer,
  input  logic [47:0] denom_sh,
  output iter_stat_t  stat,
  output logic [32:0] result
);

  logic        busy;
  logic        done;
  logic        is_div;
  logic [5:0]  cnt;
  logic [47:0] rem;
  logic [65:0] rad;
  logic [47:0] dsh;
  logic [32:0] q;

  logic [47:0] op_a;
  logic [47:0] op_b;
  logic [48:0] diff;
  logic        ge;

  always_comb begin
    op_a = is_div ? rem : {11'b0, rem[34:0], rad[65:64]};
    op_b = is_div ? dsh : {13'b0, q, 2'b01};
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[48];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.is_div ? 6'(DIV_STEPS) : 6'(SQRT_STEPS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= ge ? diff[47:0] : op_a;
      q   <= {q[31:0], ge};
      rad <= {rad[63:0], 2'b00};
      dsh <= {1'b0, dsh[47:1]};
    end else if (cmd.start) begin
      is_div <= cmd.is_div;
      rem    <= cmd.is_div ? numer : '0;
      rad    <= radicand;
      dsh    <= denom_sh;
      q      <= '0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = q;

endmodule

>>> src/segment_normal_bisector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_normal_bisector
// segment length, unit tangent, unit normal and bisector of consecutive normals
// ----------------------------------------------------------------------------
// steps: a degenerate segment takes only the length square root, one without a
// previous normal adds two divisions, a fallback bisector adds a second square root, a full
// bisector adds two more divisions; all run in turn on the shared iterative unit, and a new
// segment is accepted only in the idle state, after the last result is loaded out
// reset: clears kept normal, path flag and handshake state, tolerances to 1
module segment_normal_bisector import snb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] start_east,
  input  logic signed [31:0] start_north,
  input  logic signed [31:0] end_east,
  input  logic signed [31:0] end_north,
  input  logic               path_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [32:0]        seg_length,
  output logic signed [15:0] tangent_east,
  output logic signed [15:0] tangent_north,
  output logic signed [15:0] normal_east,
  output logic signed [15:0] normal_north,
  output logic signed [15:0] bisect_east,
  output logic signed [15:0] bisect_north,
  output logic               degenerate,
  output logic               bisect_valid,
  output logic               bisect_fallback
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MX   = 8'b0000_0010,
    S_MY   = 8'b0000_0100,
    S_ADD  = 8'b0000_1000,
    S_SQ   = 8'b0001_0000,
    S_DA   = 8'b0010_0000,
    S_DB   = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [15:0] length_tol;
  logic [15:0] bisect_tol;
  logic signed [15:0] last_e;
  logic signed [15:0] last_n;
  logic        have_last;
  logic        bis;

  logic [32:0] mx, my;
  logic        sx, sy;
  logic [65:0] prod, acc;
  logic [32:0] dvs;
  logic [32:0] div_d;
  logic [32:0] len_r;
  logic signed [15:0] qa;
  logic signed [15:0] te_r, tn_r, be_r, bn_r;
  logic        degen_r, bv_r, fb_r;

  iter_cmd_t   cmd;
  iter_stat_t  stat;
  logic [32:0] iq;
  logic [32:0] mul_in;
  logic [32:0] num_mag;
  logic        q_sign;
  logic signed [15:0] qs;
  logic signed [32:0] dx, dy;
  logic signed [16:0] se, sn;
  logic        accept;

  snb_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .radicand (acc + prod),
    .numer    ({1'b0, num_mag, 14'b0} + {16'b0, div_d[32:1]}),
    .denom_sh ({1'b0, div_d, 14'b0}),
    .stat     (stat),
    .result   (iq)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    mul_in  = (state == S_MX) ? mx : my;
    num_mag = (state == S_DA) ? my : mx;
    q_sign  = (state == S_DA) ? sx : sy;
    div_d   = (state == S_SQ) ? iq : dvs;
    qs      = q_sign ? -$signed({1'b0, iq[14:0]}) : $signed({1'b0, iq[14:0]});
    dx      = {end_east[31], end_east} - {start_east[31], start_east};
    dy      = {end_north[31], end_north} - {start_north[31], start_north};
    se      = {last_e[15], last_e} + {qs[15], qs};
    sn      = {last_n[15], last_n} - {qa[15], qa};
    cmd.start  = 1'b0;
    cmd.is_div = 1'b1;
    unique case (state)
      S_ADD: begin
        cmd.start  = 1'b1;
        cmd.is_div = 1'b0;
      end
      S_SQ: cmd.start = stat.done &&
        (bis ? (iq > {17'b0, bisect_tol}) : (iq > {17'b0, length_tol}));
      S_DA: cmd.start = stat.done;
      default: cmd.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_tol <= 16'd1;
      bisect_tol <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LENGTH_TOL: length_tol <= cfg_data;
        REG_BISECT_TOL: bisect_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_last <= 1'b0;
      last_e    <= '0;
      last_n    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (path_start) have_last <= 1'b0;
            state <= S_MX;
          end
        end
        S_MX:  state <= S_MY;
        S_MY:  state <= S_ADD;
        S_ADD: state <= S_SQ;
        S_SQ: begin
          if (stat.done) begin
            if (cmd.start) begin
              state <= S_DA;
            end else begin
              if (bis) begin
                last_e    <= tn_r;
                last_n    <= -te_r;
                have_last <= 1'b1;
              end
              state <= S_FIN;
            end
          end
        end
        S_DA: if (stat.done) state <= S_DB;
        S_DB: begin
          if (stat.done) begin
            if (bis) begin
              last_e    <= tn_r;
              last_n    <= -te_r;
              have_last <= 1'b1;
              state     <= S_FIN;
            end else if (have_last) begin
              state <= S_MX;
            end else begin
              last_e    <= qs;
              last_n    <= -qa;
              have_last <= 1'b1;
              state     <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        mx      <= dx[32] ? 33'(-dx) : 33'(dx);
        my      <= dy[32] ? 33'(-dy) : 33'(dy);
        sx      <= dx[32];
        sy      <= dy[32];
        bis     <= 1'b0;
        te_r    <= '0;
        tn_r    <= '0;
        be_r    <= '0;
        bn_r    <= '0;
        degen_r <= 1'b0;
        bv_r    <= 1'b0;
        fb_r    <= 1'b0;
      end
      S_MX: prod <= mul_in * mul_in;
      S_MY: begin
        acc  <= prod;
        prod <= mul_in * mul_in;
      end
      S_SQ: begin
        if (stat.done) begin
          dvs <= iq;
          if (!bis) begin
            len_r <= iq;
            if (!cmd.start) degen_r <= 1'b1;
          end else if (!cmd.start) begin
            fb_r <= 1'b1;
            be_r <= te_r;
            bn_r <= tn_r;
          end
        end
      end
      S_DA: if (stat.done) qa <= qs;
      S_DB: begin
        if (stat.done) begin
          if (bis) begin
            be_r <= qa;
            bn_r <= qs;
          end else begin
            te_r <= qa;
            tn_r <= qs;
            if (have_last) begin
              bis  <= 1'b1;
              bv_r <= 1'b1;
              mx   <= se[16] ? {16'b0, 17'(-se)} : {16'b0, se};
              my   <= sn[16] ? {16'b0, 17'(-sn)} : {16'b0, sn};
              sx   <= se[16];
              sy   <= sn[16];
            end
          end
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          seg_length      <= len_r;
          tangent_east    <= te_r;
          tangent_north   <= tn_r;
          normal_east     <= tn_r;
          normal_north    <= -te_r;
          bisect_east     <= be_r;
          bisect_north    <= bn_r;
          degenerate      <= degen_r;
          bisect_valid    <= bv_r;
          bisect_fallback <= fb_r;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/snb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snb_checker
// port-level checks of the segment normal and bisector block
// ----------------------------------------------------------------------------
module snb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] tangent_east,
  input logic signed [15:0] tangent_north,
  input logic               degenerate,
  input logic               bisect_valid,
  input logic               bisect_fallback
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> tangent_east == 16'sd0 && tangent_north == 16'sd0)
    else $error("degenerate item with nonzero tangent");

  a_fallback_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && bisect_fallback |-> bisect_valid)
    else $error("fallback without bisector");

  a_valid_not_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && bisect_valid |-> !degenerate)
    else $error("bisector on degenerate item");

endmodule

bind segment_normal_bisector snb_checker u_snb_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .tangent_east    (tangent_east),
  .tangent_north   (tangent_north),
  .degenerate      (degenerate),
  .bisect_valid    (bisect_valid),
  .bisect_fallback (bisect_fallback)
);

>>> tb/segment_normal_bisector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_normal_bisector_tb
// Sends path segments through the block, works out the length, tangent,
// normal and bisector of each one with its own fixed-point model, and
// compares every result item with the expected one. The run goes through
// several tolerance settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module segment_normal_bisector_tb import snb_pkg::*;;

  typedef struct {
    logic signed [31:0] se, sn, ee, en;
    logic               ps;
  } segment_t;

  typedef struct {
    logic [32:0]        len;
    logic signed [15:0] te, tn, ne, nn, be, bn;
    logic               degen, bval, bfall;
  } geometry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_LENGTH_TOL;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] start_east = '0, start_north = '0, end_east = '0, end_north = '0;
  logic path_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [32:0] seg_length;
  logic signed [15:0] tangent_east, tangent_north, normal_east, normal_north;
  logic signed [15:0] bisect_east, bisect_north;
  logic degenerate, bisect_valid, bisect_fallback;

  segment_normal_bisector DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_t  pending_segments[$];
  geometry_t expected_geometry[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off = 0;
  int        quiet_cycles = 0;

  // model state
  logic [15:0]        len_tol = 16'd1;
  logic [15:0]        bis_tol = 16'd1;
  logic signed [15:0] kept_ne = '0, kept_nn = '0;
  logic               have_kept = 1'b0;

  function automatic logic [32:0] floor_sqrt(logic [65:0] v);
    logic [32:0] res;
    logic [32:0] r;
    res = '0;
    for (int b = 32; b >= 0; b--) begin
      r = res | (33'd1 << b);
      if ({33'd0, r} * {33'd0, r} <= v) res = r;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] unit_scale(logic signed [63:0] v, logic [63:0] d);
    logic [63:0] m;
    logic [63:0] q;
    m = v < 0 ? -v : v;
    q = ((m << UNIT_FRAC_BITS) + (d >> 1)) / d;
    return v < 0 ? -q[15:0] : q[15:0];
  endfunction

  function automatic geometry_t segment_geometry(segment_t s);
    geometry_t g;
    logic signed [63:0] dx, dy, se, sn;
    logic [65:0] ax, ay;
    logic [65:0] sq;
    logic [32:0] slen;
    dx = 64'(s.ee) - 64'(s.se);
    dy = 64'(s.en) - 64'(s.sn);
    ax = {2'b00, (dx < 0 ? -dx : dx)};
    ay = {2'b00, (dy < 0 ? -dy : dy)};
    sq = ax * ax + ay * ay;
    g = '{default: '0};
    g.len = floor_sqrt(sq);
    if (s.ps) have_kept = 1'b0;
    if (g.len <= len_tol) begin
      g.degen = 1'b1;
    end else begin
      g.te = unit_scale(dx, 64'(g.len));
      g.tn = unit_scale(dy, 64'(g.len));
      g.ne = g.tn;
      g.nn = -g.te;
      if (have_kept) begin
        se = 64'(kept_ne) + 64'(g.ne);
        sn = 64'(kept_nn) + 64'(g.nn);
        slen = floor_sqrt(66'(se * se + sn * sn));
        g.bval = 1'b1;
        if (slen <= bis_tol) begin
          g.bfall = 1'b1;
          g.be = -g.nn;
          g.bn = g.ne;
        end else begin
          g.be = unit_scale(se, 64'(slen));
          g.bn = unit_scale(sn, 64'(slen));
        end
      end
      kept_ne = g.ne;
      kept_nn = g.nn;
      have_kept = 1'b1;
    end
    return g;
  endfunction

  // acceptance seen at the last rising edge
  logic in_ready_q = 1'b0;
  always @(posedge clk) in_ready_q <= in_valid && in_ready;

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_q) begin
        if (pending_segments.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          segment_t s;
          s = pending_segments.pop_front();
          expected_geometry.push_back(segment_geometry(s));
          start_east <= s.se;
          start_north <= s.sn;
          end_east <= s.ee;
          end_north <= s.en;
          path_start <= s.ps;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off <= hold_off - 1;
      end else begin
        out_ready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_geometry.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          geometry_t g;
          g = expected_geometry.pop_front();
          if (seg_length !== g.len) begin
            $error("seg_length exp %0d got %0d", g.len, seg_length); errors++;
          end
          if (tangent_east !== g.te) begin
            $error("tangent_east exp %0d got %0d", g.te, tangent_east); errors++;
          end
          if (tangent_north !== g.tn) begin
            $error("tangent_north exp %0d got %0d", g.tn, tangent_north); errors++;
          end
          if (normal_east !== g.ne) begin
            $error("normal_east exp %0d got %0d", g.ne, normal_east); errors++;
          end
          if (normal_north !== g.nn) begin
            $error("normal_north exp %0d got %0d", g.nn, normal_north); errors++;
          end
          if (bisect_east !== g.be) begin
            $error("bisect_east exp %0d got %0d", g.be, bisect_east); errors++;
          end
          if (bisect_north !== g.bn) begin
            $error("bisect_north exp %0d got %0d", g.bn, bisect_north); errors++;
          end
          if (degenerate !== g.degen) begin
            $error("degenerate exp %0d got %0d", g.degen, degenerate); errors++;
          end
          if (bisect_valid !== g.bval) begin
            $error("bisect_valid exp %0d got %0d", g.bval, bisect_valid); errors++;
          end
          if (bisect_fallback !== g.bfall) begin
            $error("bisect_fallback exp %0d got %0d", g.bfall, bisect_fallback); errors++;
          end
        end
      end
    end
  end

  task automatic add_segment(logic signed [31:0] se, sn, ee, en, logic ps);
    pending_segments.push_back('{se, sn, ee, en, ps});
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(4000)) - 2000;
      2: return $signed($urandom_range(400000)) - 200000;
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // a short path of random segments: turns random, gentle or fully reversing, some near zero
  task automatic add_path(int n);
    logic signed [31:0] px, py, nx, ny, dx, dy;
    px = rand_coord();
    py = rand_coord();
    dx = $signed($urandom_range(200000)) - 100000;
    dy = $signed($urandom_range(200000)) - 100000;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: begin dx = -dx; dy = -dy; end
        1: begin dx = $signed($urandom_range(4)) - 2; dy = $signed($urandom_range(4)) - 2; end
        2: begin dx = $urandom; dy = $urandom; end
        default: begin
          dx = dx + $signed($urandom_range(60000)) - 30000;
          dy = dy + $signed($urandom_range(60000)) - 30000;
        end
      endcase
      nx = px + dx;
      ny = py + dy;
      add_segment(px, py, nx, ny, i == 0 || $urandom_range(30) == 0);
      px = nx;
      py = ny;
    end
  endtask

  task automatic drain();
    while (pending_segments.size() != 0 || expected_geometry.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_LENGTH_TOL) len_tol = val;
    else bis_tol = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, zero length, reversal, path start on degenerate
    add_segment(0, 0, 0, 0, 1'b1);
    add_segment(0, 0, 1, 0, 1'b0);
    add_segment(0, 0, 65536, 0, 1'b0);
    add_segment(0, 0, 0, 65536, 1'b0);
    add_segment(0, 0, -65536, 0, 1'b0);
    add_segment(0, 0, 65536, 0, 1'b0);
    add_segment(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    add_segment(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b0);
    add_segment(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b0);
    add_segment(5, 5, 5, 5, 1'b1);
    add_segment(0, 0, 3, 4, 1'b0);
    add_segment(0, 0, -3, 4, 1'b0);
    add_segment(32'sh80000000, 0, 32'sh7fffffff, 0, 1'b0);
    add_segment(0, 32'sh7fffffff, 0, 32'sh80000000, 1'b1);
    add_segment(100, 100, 100, 100, 1'b0);
    add_segment(0, 0, 1, 1, 1'b0);
    add_segment(0, 0, 2, 1, 1'b0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_LENGTH_TOL, 16'd0); write_reg(REG_BISECT_TOL, 16'd0); end
        1: begin write_reg(REG_LENGTH_TOL, 16'hffff); write_reg(REG_BISECT_TOL, 16'd32768); end
        2: begin write_reg(REG_LENGTH_TOL, 16'd3); write_reg(REG_BISECT_TOL, 16'd2000); end
        3: begin write_reg(REG_LENGTH_TOL, 16'($urandom)); write_reg(REG_BISECT_TOL, 16'hffff); end
        4: begin write_reg(REG_LENGTH_TOL, 16'd1); write_reg(REG_BISECT_TOL, 16'd1); end
        default: begin
          write_reg(REG_LENGTH_TOL, 16'($urandom_range(100)));
          write_reg(REG_BISECT_TOL, 16'($urandom_range(32768)));
        end
      endcase
      send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? 50 : 0;
      recv_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? 50 : 0;
      if (phase == 5) begin
        send_idle_pct = 8;
        recv_stall_pct = 8;
      end
      if (phase == 2) hold_off = 400;
      for (int k = 0; k < 170 / 8; k++) add_path($urandom_range(2, 14));
      for (int k = 0; k < 8; k++)
        add_segment($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
